### rtl/four_neighbour_sum_stencil_defines.svh
// assertion macros used by the checker file
`ifndef FOUR_NEIGHBOUR_SUM_STENCIL_DEFINES_SVH
`define FOUR_NEIGHBOUR_SUM_STENCIL_DEFINES_SVH

// checked on every rising edge outside reset
`define FNSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked on every rising edge, reset included
`define FNSS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/fnss_pkg.sv
package fnss_pkg;

    localparam int MAX_WIDTH      = 4096;
    localparam int SAMPLE_BITS    = 32;
    localparam int SUM_BITS       = SAMPLE_BITS + 2;
    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS     = $clog2(MAX_WIDTH + 1);
    localparam int ROW_BITS       = 16;
    localparam int HEIGHT_BITS    = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = (WIDTH_BITS > HEIGHT_BITS) ? WIDTH_BITS : HEIGHT_BITS;

    // queue depth must stay a power of two, pointers wrap on their own
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = CFG_INDEX_BITS'(1);

    localparam logic [WIDTH_BITS-1:0]  RESET_WIDTH  = WIDTH_BITS'(MAX_WIDTH);
    localparam logic [HEIGHT_BITS-1:0] RESET_HEIGHT = HEIGHT_BITS'(4096);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;

    typedef struct packed {
        logic has_up;
        logic up_self;
        logic col_first;
        logic col_second;
        logic last_col;
        logic last_row;
    } item_flags_t;

    typedef struct packed {
        sample_t              sample;
        sample_t              here;
        sample_t              older;
        sample_t              right;
        sample_t              left_tap;
        sample_t              tap0;
        sample_t              tap1;
        logic [ROW_BITS-1:0]  row;
        logic [COL_BITS-1:0]  col;
        item_flags_t          flags;
    } queue_item_t;

endpackage

### rtl/fnss_ram.sv
module fnss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    // read returns the old word when the same address is written in that cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

### rtl/fnss_front.sv
module fnss_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [fnss_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [fnss_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [fnss_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                  q_full,
    output logic                                  q_push,
    output fnss_pkg::queue_item_t                 q_item
);

    import fnss_pkg::*;

    logic [WIDTH_BITS-1:0]    frame_width_reg;
    logic [HEIGHT_BITS-1:0]   frame_height_reg;
    logic [ROW_BITS-1:0]      row_reg;
    logic [ROW_BITS-1:0]      row_next;
    logic [COL_BITS-1:0]      col_reg;
    logic [COL_BITS-1:0]      col_next;
    logic [WIDTH_BITS-1:0]    width_eff;
    logic [HEIGHT_BITS-1:0]   height_eff;
    logic [ROW_BITS-1:0]      r;
    logic [COL_BITS-1:0]      c;
    logic [COL_BITS-1:0]      c_right;
    logic                     last_col;
    logic                     last_row;
    item_flags_t              flags;
    logic                     cfg_hit;
    logic                     accept;
    logic                     s1_adv;

    logic                     s1_valid_reg;
    sample_t                  s1_sample_reg;
    logic [ROW_BITS-1:0]      s1_row_reg;
    logic [COL_BITS-1:0]      s1_col_reg;
    item_flags_t              s1_flags_reg;

    logic                     fwd_here_reg;
    logic                     fwd_right_reg;
    sample_t                  fwd_sample_reg;
    sample_t                  fwd_older_reg;

    sample_t                  left_tap_reg;
    sample_t                  tap0_reg;
    sample_t                  tap1_reg;

    logic [2*SAMPLE_BITS-1:0] rd_here;
    logic [2*SAMPLE_BITS-1:0] rd_right;
    sample_t                  pv;
    sample_t                  od;
    sample_t                  rt;

    // width and height out of range fold into the usable range
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            width_eff = WIDTH_BITS'(1);
        end
        else if (frame_width_reg > WIDTH_BITS'(MAX_WIDTH))
        begin
            width_eff = WIDTH_BITS'(MAX_WIDTH);
        end
        else
        begin
            width_eff = frame_width_reg;
        end
        height_eff = (frame_height_reg == '0) ? HEIGHT_BITS'(1) : frame_height_reg;
    end

    assign c        = (WIDTH_BITS'(col_reg) >= width_eff) ? '0 : col_reg;
    assign r        = (row_reg >= ROW_BITS'(height_eff)) ? '0 : row_reg;
    assign c_right  = c + COL_BITS'(1);
    assign last_col = (WIDTH_BITS'(c) == width_eff - WIDTH_BITS'(1));
    assign last_row = (r == ROW_BITS'(height_eff - HEIGHT_BITS'(1)));

    always_comb
    begin
        flags.has_up     = (r != '0);
        flags.up_self    = (r == ROW_BITS'(1));
        flags.col_first  = (c == '0);
        flags.col_second = (c == COL_BITS'(1));
        flags.last_col   = last_col;
        flags.last_row   = last_row;
    end

    assign cfg_hit = cfg_write
                     && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
    assign full    = s1_valid_reg && q_full;
    assign accept  = push && !full;
    assign s1_adv  = s1_valid_reg && !q_full;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : r + ROW_BITS'(1);
            end
            else
            begin
                col_next = c_right;
            end
        end
    end

    // line buffer word: upper half is row r-2, lower half is row r-1
    fnss_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk       (clk),
        .wr_en     (s1_adv),
        .wr_addr   (s1_col_reg),
        .wr_data   ({pv, s1_sample_reg}),
        .rd_en     (accept),
        .rd_addr_a (c),
        .rd_data_a (rd_here),
        .rd_addr_b (c_right),
        .rd_data_b (rd_right)
    );

    // the word written in the accept cycle is not yet visible in the ram read
    assign pv = fwd_here_reg  ? fwd_sample_reg : rd_here[SAMPLE_BITS-1:0];
    assign od = fwd_here_reg  ? fwd_older_reg  : rd_here[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign rt = fwd_right_reg ? fwd_sample_reg : rd_right[SAMPLE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RESET_WIDTH;
            frame_height_reg <= RESET_HEIGHT;
            row_reg          <= '0;
            col_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            fwd_here_reg     <= 1'b0;
            fwd_right_reg    <= 1'b0;
            left_tap_reg     <= '0;
            tap0_reg         <= '0;
            tap1_reg         <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[WIDTH_BITS-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[HEIGHT_BITS-1:0];
                    default:          ;
                endcase
            end

            if (cfg_hit)
            begin
                row_reg      <= '0;
                col_reg      <= '0;
                left_tap_reg <= '0;
                tap0_reg     <= '0;
                tap1_reg     <= '0;
            end
            else
            begin
                row_reg <= row_next;
                col_reg <= col_next;
                if (s1_adv)
                begin
                    left_tap_reg <= pv;
                    tap1_reg     <= tap0_reg;
                    tap0_reg     <= s1_sample_reg;
                end
            end

            if (accept)
            begin
                s1_valid_reg  <= 1'b1;
                fwd_here_reg  <= s1_adv && (s1_col_reg == c);
                fwd_right_reg <= s1_adv && (s1_col_reg == c_right);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg  <= sample;
            s1_row_reg     <= r;
            s1_col_reg     <= c;
            s1_flags_reg   <= flags;
            fwd_sample_reg <= s1_sample_reg;
            fwd_older_reg  <= pv;
        end
    end

    assign q_push = s1_adv;

    always_comb
    begin
        q_item.sample   = s1_sample_reg;
        q_item.here     = pv;
        q_item.older    = od;
        q_item.right    = rt;
        q_item.left_tap = left_tap_reg;
        q_item.tap0     = tap0_reg;
        q_item.tap1     = tap1_reg;
        q_item.row      = s1_row_reg;
        q_item.col      = s1_col_reg;
        q_item.flags    = s1_flags_reg;
    end

endmodule

### rtl/fnss_queue.sv
module fnss_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  fnss_pkg::queue_item_t push_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output fnss_pkg::queue_item_t head_item
);

    import fnss_pkg::*;

    queue_item_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg;
    logic                      do_push;
    logic                      do_pop;

    assign full       = (count_reg == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (QUEUE_PTR_BITS + 1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (QUEUE_PTR_BITS + 1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/fnss_back.sv
module fnss_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 head_valid,
    input  fnss_pkg::queue_item_t                head_item,
    output logic                                 q_pop,
    input  logic                                 pop,
    output logic                                 empty,
    output logic signed [fnss_pkg::SUM_BITS-1:0] neighbour_sum,
    output logic [fnss_pkg::ROW_BITS-1:0]        out_row,
    output logic [fnss_pkg::COL_BITS-1:0]        out_col,
    output logic                                 last_of_item,
    output logic                                 end_of_frame
);

    import fnss_pkg::*;

    localparam logic [1:0] KIND_UP_ROW   = 2'd0;
    localparam logic [1:0] KIND_LAST_ROW = 2'd1;
    localparam logic [1:0] KIND_CORNER   = 2'd2;

    logic                up_done_reg;
    logic                last_done_reg;
    logic                out_valid_reg;
    sum_t                sum_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic [COL_BITS-1:0] col_reg;
    logic                last_reg;
    logic                eof_reg;

    logic                need_up;
    logic                need_last;
    logic                need_corner;
    logic                any_need;
    logic                final_one;
    logic [1:0]          kind;
    logic                go;
    sample_t             op0;
    sample_t             op1;
    sample_t             op2;
    sample_t             op3;
    sum_t                ext0;
    sum_t                ext1;
    sum_t                ext2;
    sum_t                ext3;
    sum_t                sum;
    logic [ROW_BITS-1:0] row_sel;
    logic [COL_BITS-1:0] col_sel;

    // results of one entry go out in order: row above, last row left, corner
    assign need_up     = head_item.flags.has_up && !up_done_reg;
    assign need_last   = head_item.flags.last_row && !head_item.flags.col_first
                         && !last_done_reg;
    assign need_corner = head_item.flags.last_row && head_item.flags.last_col;
    assign any_need    = need_up || need_last || need_corner;

    always_comb
    begin
        if (need_up)
        begin
            kind      = KIND_UP_ROW;
            final_one = !(need_last || need_corner);
        end
        else if (need_last)
        begin
            kind      = KIND_LAST_ROW;
            final_one = !need_corner;
        end
        else
        begin
            kind      = KIND_CORNER;
            final_one = 1'b1;
        end
    end

    assign go    = head_valid && (!out_valid_reg || pop);
    assign q_pop = go && (!any_need || final_one);

    // missing neighbours fall back to the position's own sample
    always_comb
    begin
        case (kind)
            KIND_UP_ROW:
            begin
                op0     = head_item.flags.up_self ? head_item.here : head_item.older;
                op1     = head_item.sample;
                op2     = head_item.flags.col_first ? head_item.here : head_item.left_tap;
                op3     = head_item.flags.last_col ? head_item.here : head_item.right;
                row_sel = head_item.row - ROW_BITS'(1);
                col_sel = head_item.col;
            end
            KIND_LAST_ROW:
            begin
                op0     = head_item.flags.has_up ? head_item.left_tap : head_item.tap0;
                op1     = head_item.tap0;
                op2     = head_item.flags.col_second ? head_item.tap0 : head_item.tap1;
                op3     = head_item.sample;
                row_sel = head_item.row;
                col_sel = head_item.col - COL_BITS'(1);
            end
            KIND_CORNER:
            begin
                op0     = head_item.flags.has_up ? head_item.here : head_item.sample;
                op1     = head_item.sample;
                op2     = head_item.flags.col_first ? head_item.sample : head_item.tap0;
                op3     = head_item.sample;
                row_sel = head_item.row;
                col_sel = head_item.col;
            end
            default:
            begin
                op0     = '0;
                op1     = '0;
                op2     = '0;
                op3     = '0;
                row_sel = '0;
                col_sel = '0;
            end
        endcase
    end

    assign ext0 = sum_t'(op0);
    assign ext1 = sum_t'(op1);
    assign ext2 = sum_t'(op2);
    assign ext3 = sum_t'(op3);
    assign sum  = ext0 + ext1 + ext2 + ext3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_done_reg   <= 1'b0;
            last_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                up_done_reg   <= 1'b0;
                last_done_reg <= 1'b0;
            end
            else if (go && any_need)
            begin
                if (kind == KIND_UP_ROW)
                begin
                    up_done_reg <= 1'b1;
                end
                if (kind == KIND_LAST_ROW)
                begin
                    last_done_reg <= 1'b1;
                end
            end

            if (go && any_need)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && any_need)
        begin
            sum_reg  <= sum;
            row_reg  <= row_sel;
            col_reg  <= col_sel;
            last_reg <= final_one;
            eof_reg  <= (kind == KIND_CORNER);
        end
    end

    assign empty         = !out_valid_reg;
    assign neighbour_sum = sum_reg;
    assign out_row       = row_reg;
    assign out_col       = col_reg;
    assign last_of_item  = last_reg;
    assign end_of_frame  = eof_reg;

endmodule

### rtl/four_neighbour_sum_stencil.sv
// channel   handshake          payload
// input     push / full        sample
// result    empty / pop        neighbour_sum, out_row, out_col, last_of_item, end_of_frame
// config    cfg_write          cfg_index, cfg_data
//
// one sample is taken per clock while full is low and is registered in the front stage,
// the 4-entry queue between the ends and the back end; a last-row sample gives up to three
// words, sent one per clock from the back end while pop keeps up, and can fill the queue
// reset or a width or height write restarts the frame at row 0, column 0; line buffer kept
// full rises only when the front stage holds a word and the queue is full

module four_neighbour_sum_stencil
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [fnss_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [fnss_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                                    push,
    output logic                                    full,
    input  logic signed [fnss_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                    empty,
    input  logic                                    pop,
    output logic signed [fnss_pkg::SUM_BITS-1:0]    neighbour_sum,
    output logic [fnss_pkg::ROW_BITS-1:0]           out_row,
    output logic [fnss_pkg::COL_BITS-1:0]           out_col,
    output logic                                    last_of_item,
    output logic                                    end_of_frame
);

    import fnss_pkg::*;

    logic        q_push;
    logic        q_full;
    queue_item_t q_item;
    logic        head_valid;
    queue_item_t head_item;
    logic        q_pop;

    fnss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .sample    (sample),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    fnss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    fnss_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_item     (head_item),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .neighbour_sum (neighbour_sum),
        .out_row       (out_row),
        .out_col       (out_col),
        .last_of_item  (last_of_item),
        .end_of_frame  (end_of_frame)
    );

endmodule

### rtl/fnss_checker.sv
`include "four_neighbour_sum_stencil_defines.svh"

module fnss_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          empty,
    input logic                          pop,
    input logic [fnss_pkg::ROW_BITS-1:0] out_row,
    input logic                          last_of_item,
    input logic                          end_of_frame
);

    // nothing waits on the result side once reset has been seen at an edge
    `FNSS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> empty, "result pending after reset")

    // the frame's closing word is always the last word of its sample
    `FNSS_ASSERT(a_eof_last, !empty && end_of_frame |-> last_of_item, "eof word not last")

    // the rest of a sample's words follow at once, same row or the one below
    `FNSS_ASSERT(a_item_run,
        pop && !empty && !last_of_item |=> !empty
            && (out_row == $past(out_row) || out_row == $past(out_row) + 1'b1),
        "broken word run within sample")

    `FNSS_ASSERT(a_hold, !empty && !pop |=> !empty, "result word dropped while stalled")

endmodule

bind four_neighbour_sum_stencil fnss_checker u_fnss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .out_row      (out_row),
    .last_of_item (last_of_item),
    .end_of_frame (end_of_frame)
);

### dv/four_neighbour_sum_stencil_tb.sv
module four_neighbour_sum_stencil_tb;

    import fnss_pkg::*;

    localparam int SETTLE_CYCLES    = 8;
    localparam int RANDOM_PER_PHASE = 80;
    localparam int EDGE_SAMPLES     = 24;
    localparam int RUN_LIMIT        = 6_000_000;
    localparam int PRINT_CAP        = 40;

    // index with no register behind it: the write is dropped, position kept
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = CFG_INDEX_BITS'(2);

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct {
        sum_t                 total;
        logic [ROW_BITS-1:0]  row;
        logic [COL_BITS-1:0]  col;
        logic                 last;
        logic                 eof;
    } stencil_word_t;

    typedef enum logic {STEP_SAMPLE, STEP_WRITE} step_kind_t;

    typedef struct {
        step_kind_t                 kind;
        logic [CFG_INDEX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0]   data;
        sample_t                    value;
        bit                         typed;
        stencil_word_t              result;
    } directed_step_t;

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_data  = '0;
    logic                       push      = 1'b0;
    logic                       full;
    sample_t                    sample    = '0;
    logic                       empty;
    logic                       pop       = 1'b0;
    sum_t                       neighbour_sum;
    logic [ROW_BITS-1:0]        out_row;
    logic [COL_BITS-1:0]        out_col;
    logic                       last_of_item;
    logic                       end_of_frame;

    // stencil state as seen from outside
    logic [WIDTH_BITS-1:0]      cfg_w = RESET_WIDTH;
    logic [HEIGHT_BITS-1:0]     cfg_h = RESET_HEIGHT;
    sample_t                    line_prev  [MAX_WIDTH];
    sample_t                    line_older [MAX_WIDTH];
    int unsigned                at_row = 0;
    int unsigned                at_col = 0;
    sample_t                    tap_near = '0;
    sample_t                    tap_far = '0;
    sample_t                    prev_left = '0;

    stencil_word_t              pending_sums [$];

    int idle_pct      = 0;
    int stall_pct     = 0;
    int errors        = 0;
    int samples_sent  = 0;
    int sums_checked  = 0;
    int frames_closed = 0;
    int writes_done   = 0;

    directed_step_t directed_steps [38] = '{
        // default 4096 x 4096 frame, row 0 gives nothing
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     SAMPLE_MAX,   1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     SAMPLE_MIN,   1'b0, '{0, 0, 0, 0, 0}},
        // 1 x 1 frame: every neighbour is the sample itself
        '{STEP_WRITE,  REG_FRAME_WIDTH,  16'd1,     32'sd0,       1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_WRITE,  REG_FRAME_HEIGHT, 16'd1,     32'sd0,       1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     32'sd5,       1'b1,
          '{34'sd20, 16'd0, 12'd0, 1'b1, 1'b1}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     SAMPLE_MAX,   1'b1,
          '{34'sh1_FFFF_FFFC, 16'd0, 12'd0, 1'b1, 1'b1}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     SAMPLE_MIN,   1'b1,
          '{34'sh2_0000_0000, 16'd0, 12'd0, 1'b1, 1'b1}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     -32'sd1,      1'b1,
          '{-34'sd4, 16'd0, 12'd0, 1'b1, 1'b1}},
        // zero width and height behave as one
        '{STEP_WRITE,  REG_FRAME_WIDTH,  16'd0,     32'sd0,       1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_WRITE,  REG_FRAME_HEIGHT, 16'd0,     32'sd0,       1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     32'sd3,       1'b1,
          '{34'sd12, 16'd0, 12'd0, 1'b1, 1'b1}},
        // upper data bits above the width register are dropped
        '{STEP_WRITE,  REG_FRAME_WIDTH,  16'hE003,  32'sd0,       1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_WRITE,  REG_FRAME_HEIGHT, 16'd2,     32'sd0,       1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     32'sd1,       1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     -32'sd2,      1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     SAMPLE_MAX,   1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     SAMPLE_MIN,   1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     32'sd100,     1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     -32'sd1,      1'b0, '{0, 0, 0, 0, 0}},
        // single column, spare index written mid frame
        '{STEP_WRITE,  REG_FRAME_WIDTH,  16'd1,     32'sd0,       1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_WRITE,  REG_FRAME_HEIGHT, 16'd3,     32'sd0,       1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     32'sd9,       1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_WRITE,  REG_SPARE,        16'hFFFF,  32'sd0,       1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     SAMPLE_MIN,   1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     SAMPLE_MAX,   1'b0, '{0, 0, 0, 0, 0}},
        // tallest frame, only its first rows
        '{STEP_WRITE,  REG_FRAME_WIDTH,  16'd2,     32'sd0,       1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_WRITE,  REG_FRAME_HEIGHT, 16'hFFFF,  32'sd0,       1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     32'sd4,       1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     -32'sd8,      1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     SAMPLE_MAX,   1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     32'sd0,       1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_WRITE,  REG_FRAME_HEIGHT, 16'd3,     32'sd0,       1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     32'sd11,      1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     -32'sd13,     1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     SAMPLE_MIN,   1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     32'sd17,      1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     SAMPLE_MAX,   1'b0, '{0, 0, 0, 0, 0}},
        '{STEP_SAMPLE, REG_FRAME_WIDTH,  16'd0,     -32'sd1,      1'b0, '{0, 0, 0, 0, 0}}
    };

    four_neighbour_sum_stencil DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .push           (push),
        .full           (full),
        .sample         (sample),
        .empty          (empty),
        .pop            (pop),
        .neighbour_sum  (neighbour_sum),
        .out_row        (out_row),
        .out_col        (out_col),
        .last_of_item   (last_of_item),
        .end_of_frame   (end_of_frame)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic sum_t sum_of_four(input sample_t a, input sample_t b,
                                         input sample_t c, input sample_t d);
        return sum_t'(a) + sum_t'(b) + sum_t'(c) + sum_t'(d);
    endfunction

    function automatic stencil_word_t word_of(input sum_t total, input int unsigned row,
                                              input int unsigned col, input logic eof);
        return '{total, ROW_BITS'(row), COL_BITS'(col), 1'b0, eof};
    endfunction

    function automatic sample_t random_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return sample_t'($urandom_range(0, 4)) - sample_t'(2);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // sums due from one sample; advances the frame position and line stores
    function automatic void predict_sample(input sample_t s, output stencil_word_t words [$]);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        sample_t above;
        sample_t older;
        sample_t up;
        sample_t left;
        sample_t right;
        sample_t here;
        bit bottom;
        bit rightmost;
        words = {};
        w = (cfg_w == 0) ? 1 : cfg_w;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        h = (cfg_h == 0) ? 1 : cfg_h;
        if (at_col >= w)
            at_col = 0;
        if (at_row >= h)
            at_row = 0;
        r = at_row;
        c = at_col;
        above = line_prev[c];
        older = line_older[c];
        bottom = (r == h - 1);
        rightmost = (c == w - 1);
        if (r >= 1)
        begin
            up = (r == 1) ? above : older;
            left = (c == 0) ? above : prev_left;
            if (rightmost)
                right = above;
            else
                right = line_prev[c + 1];
            words.push_back(word_of(sum_of_four(up, s, left, right), r - 1, c, 1'b0));
        end
        // last row also closes the position to the left
        if (bottom && c >= 1)
        begin
            here = tap_near;
            up = (r >= 1) ? prev_left : here;
            left = (c == 1) ? here : tap_far;
            words.push_back(word_of(sum_of_four(up, here, left, s), r, c - 1, 1'b0));
        end
        if (bottom && rightmost)
        begin
            up = (r >= 1) ? above : s;
            left = (c >= 1) ? tap_near : s;
            words.push_back(word_of(sum_of_four(up, s, left, s), r, c, 1'b1));
        end
        if (words.size() > 0)
            words[words.size() - 1].last = 1'b1;
        line_older[c] = above;
        line_prev[c] = s;
        prev_left = above;
        tap_far = tap_near;
        tap_near = s;
        if (rightmost)
        begin
            at_col = 0;
            at_row = bottom ? 0 : r + 1;
        end
        else
            at_col = c + 1;
    endfunction

    task automatic send_sample(input sample_t value, input bit typed,
                               input stencil_word_t given);
        stencil_word_t words [$];
        while ($urandom_range(0, 99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        sample <= value;
        do
            @(posedge clk);
        while (full);
        samples_sent++;
        predict_sample(value, words);
        if (typed)
            words = '{given};
        foreach (words[i])
            pending_sums.push_back(words[i]);
    endtask

    // hold the sender until every expected word is out, then let the pipe settle
    task automatic wait_for_drain();
        push <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        writes_done++;
        if (index == REG_FRAME_WIDTH)
            cfg_w = value[WIDTH_BITS-1:0];
        else if (index == REG_FRAME_HEIGHT)
            cfg_h = value[HEIGHT_BITS-1:0];
        if (index == REG_FRAME_WIDTH || index == REG_FRAME_HEIGHT)
        begin
            at_row = 0;
            at_col = 0;
            tap_near = '0;
            tap_far = '0;
            prev_left = '0;
        end
    endtask

    // result side: check each popped word, then pick the next pop
    initial
    begin
        stencil_word_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (pending_sums.size() == 0)
                begin
                    if (errors < PRINT_CAP)
                        $display("%0t: unexpected word: sum %0d row %0d col %0d", $time,
                                 neighbour_sum, out_row, out_col);
                    errors++;
                end
                else
                begin
                    want = pending_sums.pop_front();
                    sums_checked++;
                    if (end_of_frame === 1'b1)
                        frames_closed++;
                    if ({neighbour_sum, out_row, out_col, last_of_item, end_of_frame} !==
                        {want.total, want.row, want.col, want.last, want.eof})
                    begin
                        if (errors < PRINT_CAP)
                        begin
                            $display("%0t: expected sum %0d row %0d col %0d last %0b eof %0b",
                                     $time, want.total, want.row, want.col, want.last,
                                     want.eof);
                            $display("%0t:   actual sum %0d row %0d col %0d last %0b eof %0b",
                                     $time, neighbour_sum, out_row, out_col, last_of_item,
                                     end_of_frame);
                        end
                        errors++;
                    end
                end
            end
            pop <= rst_n && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("timeout at %0t with %0d words outstanding", $time, pending_sums.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        stencil_word_t no_word;
        logic [WIDTH_BITS-1:0] new_w;
        logic [HEIGHT_BITS-1:0] new_h;
        int eff_w;
        int eff_h;
        int count;
        int pause_at;
        int phase_start;
        int guard;
        no_word = '{0, 0, 0, 0, 0};
        foreach (line_prev[i])
        begin
            line_prev[i] = '0;
            line_older[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 26;
        stall_pct = 26;
        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == STEP_WRITE)
            begin
                wait_for_drain();
                write_register(directed_steps[i].index, directed_steps[i].data);
            end
            else
                send_sample(directed_steps[i].value, directed_steps[i].typed,
                            directed_steps[i].result);
        end

        // over-range width that clamps, single row so every sample past the first answers
        idle_pct = 0;
        stall_pct = 0;
        wait_for_drain();
        write_register(REG_FRAME_WIDTH, 16'h1FFF);
        write_register(REG_FRAME_HEIGHT, CFG_DATA_BITS'(1));
        for (int k = 0; k < EDGE_SAMPLES; k++)
        begin
            // sender holds off partway along the row
            if (k == EDGE_SAMPLES / 2)
                wait_for_drain();
            send_sample(random_sample(), 1'b0, no_word);
        end

        for (int mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 81;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 81;
                end
                default:
                begin
                    idle_pct = 26;
                    stall_pct = 26;
                end
            endcase
            phase_start = samples_sent;
            while (samples_sent - phase_start < RANDOM_PER_PHASE)
            begin
                case ($urandom_range(0, 9))
                    0: new_w = '0;
                    8, 9: new_w = WIDTH_BITS'($urandom_range(7, 24));
                    default: new_w = WIDTH_BITS'($urandom_range(1, 6));
                endcase
                case ($urandom_range(0, 9))
                    0: new_h = '0;
                    1: new_h = '1;
                    default: new_h = HEIGHT_BITS'($urandom_range(1, 5));
                endcase
                eff_w = (new_w == 0) ? 1 : new_w;
                eff_h = (new_h == 0) ? 1 : new_h;
                wait_for_drain();
                write_register(REG_FRAME_WIDTH, {3'($urandom), new_w});
                write_register(REG_FRAME_HEIGHT, new_h);
                if ($urandom_range(0, 15) == 0)
                    write_register(REG_SPARE, CFG_DATA_BITS'($urandom));
                // tall frames only get their first rows; others run one or two whole frames, at times plus part of one
                if (new_h == '1)
                    count = eff_w * $urandom_range(2, 4);
                else
                begin
                    count = eff_w * eff_h * $urandom_range(1, 2);
                    if ($urandom_range(0, 3) == 0)
                        count += $urandom_range(1, eff_w * eff_h);
                end
                pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, count - 1) : -1;
                for (int k = 0; k < count; k++)
                begin
                    if (k == pause_at)
                        wait_for_drain();
                    send_sample(random_sample(), 1'b0, no_word);
                end
            end
        end

        push <= 1'b0;
        guard = 0;
        while (pending_sums.size() != 0 && guard < 200_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (pending_sums.size() != 0)
        begin
            $display("%0d expected words never arrived", pending_sums.size());
            errors += pending_sums.size();
        end
        $display("sent %0d samples across %0d register writes, widths 1 to %0d",
                 samples_sent, writes_done, MAX_WIDTH);
        $display("checked %0d sums, %0d frame ends, %0d errors",
                 sums_checked, frames_closed, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/fnss_pkg.sv
rtl/fnss_ram.sv
rtl/fnss_front.sv
rtl/fnss_queue.sv
rtl/fnss_back.sv
rtl/four_neighbour_sum_stencil.sv
rtl/fnss_checker.sv
dv/four_neighbour_sum_stencil_tb.sv
